[hw/rtl/iqrs_pkg.sv]
// shared types and constants for the indexed queue with range sort
package iqrs_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = ADDR_W + 1;
    localparam int WORD_W   = 32;

    typedef enum logic [2:0] {
        MODE_PUSH  = 3'd0,
        MODE_POP   = 3'd1,
        MODE_PEEK  = 3'd2,
        MODE_READ  = 3'd3,
        MODE_WRITE = 3'd4,
        MODE_DROP  = 3'd5,
        MODE_CLEAR = 3'd6,
        MODE_SORT  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SORT_KEY,
        ST_SORT_LOAD,
        ST_SORT_CMP,
        ST_SORT_PLACE,
        ST_SORT_NEXT
    } state_t;

endpackage

[hw/rtl/indexed_queue_with_range_sort.sv]
// indexed queue with range sort: top level, circular word store in one memory
//
// input channel in_valid/in_ready carries mode, value, index and index_high;
// output channel out_valid/out_ready carries data, entry_count and status.
// one result is returned per input transaction, in order.
// one transaction is handled at a time: in_ready is high only while no
// operation is in progress and the result register is empty or being taken.
// push, write, drop, clear and every error give a registered result in the
// cycle after acceptance; pop, peek and indexed read pass through the memory
// read register and then the result register. a range sort of
// n = index_high - index + 1 words runs an insertion sort through the single
// memory port pair, shifting larger words up one place and writing each key
// into the gap; the input is held off until it ends.
// when the receiver stalls, the result stays in the output register and no
// new transaction is accepted until it is taken.
// reset empties the queue and puts the head at slot 0; memory contents are
// not cleared and need no clearing pass.
module indexed_queue_with_range_sort (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          mode,
    input  logic signed [iqrs_pkg::WORD_W-1:0]  value,
    input  logic [iqrs_pkg::COUNT_W-1:0]        index,
    input  logic [iqrs_pkg::ADDR_W-1:0]         index_high,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [iqrs_pkg::WORD_W-1:0]  data,
    output logic [iqrs_pkg::COUNT_W-1:0]        entry_count,
    output logic [1:0]                          status
);

    localparam int AW = iqrs_pkg::ADDR_W;
    localparam int CW = iqrs_pkg::COUNT_W;
    localparam int WW = iqrs_pkg::WORD_W;

    iqrs_pkg::state_t  state_reg, state_next;
    iqrs_pkg::status_t status_reg, status_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [AW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     hi_reg, hi_next;
    logic [WW-1:0]     key_reg, key_next;
    logic [WW-1:0]     data_reg, data_next;
    logic              out_valid_reg, out_valid_next;

    logic [WW-1:0]     mem [iqrs_pkg::CAPACITY];
    logic [WW-1:0]     rdata_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [WW-1:0]     mem_wdata;

    logic              accept;
    iqrs_pkg::mode_t   op;
    logic              op_err;
    iqrs_pkg::status_t op_status;
    logic              op_read;
    logic              op_sort;
    logic              cmp_gt;
    logic [AW-1:0]     j_dec;

    assign in_ready    = (state_reg == iqrs_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign op          = iqrs_pkg::mode_t'(mode);
    assign out_valid   = out_valid_reg;
    assign data        = data_reg;
    assign entry_count = count_reg;
    assign status      = status_reg;
    assign cmp_gt      = $signed(rdata_reg) > $signed(key_reg);
    assign j_dec       = j_reg - AW'(1);

    // classify the incoming operation
    always_comb
    begin
        op_err    = 1'b0;
        op_status = iqrs_pkg::STATUS_OK;
        op_read   = 1'b0;
        op_sort   = 1'b0;
        case (op)
            iqrs_pkg::MODE_PUSH:
            begin
                if (count_reg >= CW'(iqrs_pkg::CAPACITY))
                begin
                    op_err    = 1'b1;
                    op_status = iqrs_pkg::STATUS_FULL;
                end
            end
            iqrs_pkg::MODE_POP, iqrs_pkg::MODE_PEEK:
            begin
                if (count_reg == '0)
                begin
                    op_err    = 1'b1;
                    op_status = iqrs_pkg::STATUS_EMPTY;
                end
                else
                begin
                    op_read = 1'b1;
                end
            end
            iqrs_pkg::MODE_READ, iqrs_pkg::MODE_WRITE:
            begin
                if (index >= count_reg)
                begin
                    op_err    = 1'b1;
                    op_status = iqrs_pkg::STATUS_RANGE;
                end
                else
                begin
                    op_read = (op == iqrs_pkg::MODE_READ);
                end
            end
            iqrs_pkg::MODE_DROP:
            begin
                if (index > count_reg)
                begin
                    op_err    = 1'b1;
                    op_status = iqrs_pkg::STATUS_RANGE;
                end
            end
            iqrs_pkg::MODE_SORT:
            begin
                if (index >= count_reg || CW'(index_high) >= count_reg)
                begin
                    op_err    = 1'b1;
                    op_status = iqrs_pkg::STATUS_RANGE;
                end
                else
                begin
                    op_sort = index < CW'(index_high);
                end
            end
            default:
            begin
                op_err = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iqrs_pkg::ST_IDLE:
            begin
                if (accept && op_read)
                    state_next = iqrs_pkg::ST_READ;
                else if (accept && op_sort)
                    state_next = iqrs_pkg::ST_SORT_KEY;
            end
            iqrs_pkg::ST_READ:
                state_next = iqrs_pkg::ST_IDLE;
            iqrs_pkg::ST_SORT_KEY:
                state_next = iqrs_pkg::ST_SORT_LOAD;
            iqrs_pkg::ST_SORT_LOAD:
                state_next = iqrs_pkg::ST_SORT_CMP;
            iqrs_pkg::ST_SORT_CMP:
            begin
                if (!cmp_gt)
                    state_next = iqrs_pkg::ST_SORT_NEXT;
                else if (j_dec <= lo_reg)
                    state_next = iqrs_pkg::ST_SORT_PLACE;
            end
            iqrs_pkg::ST_SORT_PLACE:
                state_next = iqrs_pkg::ST_SORT_NEXT;
            iqrs_pkg::ST_SORT_NEXT:
            begin
                if (i_reg == hi_reg)
                    state_next = iqrs_pkg::ST_IDLE;
                else
                    state_next = iqrs_pkg::ST_SORT_KEY;
            end
            default:
                state_next = iqrs_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = head_reg + j_reg;
        mem_raddr      = head_reg;
        mem_wdata      = key_reg;
        case (state_reg)
            iqrs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = op_status;
                    data_next   = '0;
                    if (!op_read && !op_sort)
                        out_valid_next = 1'b1;
                    if (!op_err)
                    begin
                        case (op)
                            iqrs_pkg::MODE_PUSH:
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = head_reg + count_reg[AW-1:0];
                                mem_wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                            iqrs_pkg::MODE_POP:
                            begin
                                mem_re     = 1'b1;
                                head_next  = head_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                            end
                            iqrs_pkg::MODE_PEEK:
                                mem_re = 1'b1;
                            iqrs_pkg::MODE_READ:
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = head_reg + index[AW-1:0];
                            end
                            iqrs_pkg::MODE_WRITE:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = head_reg + index[AW-1:0];
                                mem_wdata = value;
                            end
                            iqrs_pkg::MODE_DROP:
                            begin
                                head_next  = head_reg + index[AW-1:0];
                                count_next = count_reg - index;
                            end
                            iqrs_pkg::MODE_CLEAR:
                            begin
                                head_next  = '0;
                                count_next = '0;
                            end
                            iqrs_pkg::MODE_SORT:
                            begin
                                lo_next = index[AW-1:0];
                                hi_next = index_high;
                                i_next  = index[AW-1:0] + AW'(1);
                            end
                            default:
                                head_next = head_reg;
                        endcase
                    end
                end
            end
            iqrs_pkg::ST_READ:
            begin
                data_next      = rdata_reg;
                out_valid_next = 1'b1;
            end
            iqrs_pkg::ST_SORT_KEY:
            begin
                mem_re    = 1'b1;
                mem_raddr = head_reg + i_reg;
                j_next    = i_reg;
            end
            iqrs_pkg::ST_SORT_LOAD:
            begin
                key_next  = rdata_reg;
                mem_re    = 1'b1;
                mem_raddr = head_reg + j_dec;
            end
            iqrs_pkg::ST_SORT_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    // shift the larger word up one place and look further down
                    mem_wdata = rdata_reg;
                    j_next    = j_dec;
                    mem_re    = j_dec > lo_reg;
                    mem_raddr = head_reg + j_dec - AW'(1);
                end
            end
            iqrs_pkg::ST_SORT_PLACE:
                mem_we = 1'b1;
            iqrs_pkg::ST_SORT_NEXT:
            begin
                if (i_reg == hi_reg)
                    out_valid_next = 1'b1;
                else
                    i_next = i_reg + AW'(1);
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iqrs_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= iqrs_pkg::STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        key_reg  <= key_next;
        data_reg <= data_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(iqrs_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != iqrs_pkg::ST_IDLE) |-> !out_valid_reg)
        else $error("result pending while an operation is in progress");

    a_sort_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iqrs_pkg::ST_SORT_CMP) |=> $stable(count_reg) && $stable(head_reg))
        else $error("queue pointers moved during a sort");
`endif

endmodule

[tb/sv/tb_indexed_queue_with_range_sort.sv]
// self-checking testbench for the indexed queue with range sort
module tb_indexed_queue_with_range_sort;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        iqrs_pkg::mode_t                     op;
        logic signed [iqrs_pkg::WORD_W-1:0]  word;
        logic [iqrs_pkg::COUNT_W-1:0]        pos;
        logic [iqrs_pkg::ADDR_W-1:0]         pos_high;
        int                                  gap;
    } queue_op_t;

    typedef struct {
        logic signed [iqrs_pkg::WORD_W-1:0]  word;
        logic [iqrs_pkg::COUNT_W-1:0]        count;
        iqrs_pkg::status_t                   stat;
    } queue_result_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_ready;
    iqrs_pkg::mode_t                       mode;
    logic signed [iqrs_pkg::WORD_W-1:0]    value;
    logic [iqrs_pkg::COUNT_W-1:0]          index;
    logic [iqrs_pkg::ADDR_W-1:0]           index_high;
    logic                                  out_valid;
    logic                                  out_ready;
    logic signed [iqrs_pkg::WORD_W-1:0]    data;
    logic [iqrs_pkg::COUNT_W-1:0]          entry_count;
    logic [1:0]                            status;

    indexed_queue_with_range_sort uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .value       (value),
        .index       (index),
        .index_high  (index_high),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data        (data),
        .entry_count (entry_count),
        .status      (status)
    );

    queue_op_t      pending_ops[$];
    queue_result_t  expected_results[$];

    // shadow of the queue used for prediction
    logic signed [iqrs_pkg::WORD_W-1:0]  shadow_mem[iqrs_pkg::CAPACITY];
    logic [iqrs_pkg::ADDR_W-1:0]         shadow_head;
    logic [iqrs_pkg::COUNT_W-1:0]        shadow_count;

    int  gen_count;
    int  errors;
    int  accepted;
    int  results_seen;
    int  sorts_done;
    int  full_hits;
    int  cycles;
    int  gap_left;
    int  hold_left;
    bit  long_hold_done;
    bit  in_took;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [iqrs_pkg::ADDR_W-1:0] slot_at(input int pos);
        return shadow_head + pos[iqrs_pkg::ADDR_W-1:0];
    endfunction

    // one queue operation applied to the shadow, giving its result
    function automatic queue_result_t apply_queue_op(input queue_op_t t);
        queue_result_t r;
        logic signed [iqrs_pkg::WORD_W-1:0] key;
        int cnt;
        int j;
        r.word = '0;
        r.stat = iqrs_pkg::STATUS_OK;
        cnt = shadow_count;
        case (t.op)
            iqrs_pkg::MODE_PUSH:
                if (cnt >= iqrs_pkg::CAPACITY)
                    r.stat = iqrs_pkg::STATUS_FULL;
                else
                begin
                    shadow_mem[slot_at(cnt)] = t.word;
                    shadow_count = shadow_count + 1;
                end
            iqrs_pkg::MODE_POP:
                if (cnt == 0)
                    r.stat = iqrs_pkg::STATUS_EMPTY;
                else
                begin
                    r.word = shadow_mem[shadow_head];
                    shadow_head = shadow_head + 1;
                    shadow_count = shadow_count - 1;
                end
            iqrs_pkg::MODE_PEEK:
                if (cnt == 0)
                    r.stat = iqrs_pkg::STATUS_EMPTY;
                else
                    r.word = shadow_mem[shadow_head];
            iqrs_pkg::MODE_READ:
                if (t.pos >= cnt)
                    r.stat = iqrs_pkg::STATUS_RANGE;
                else
                    r.word = shadow_mem[slot_at(t.pos)];
            iqrs_pkg::MODE_WRITE:
                if (t.pos >= cnt)
                    r.stat = iqrs_pkg::STATUS_RANGE;
                else
                    shadow_mem[slot_at(t.pos)] = t.word;
            iqrs_pkg::MODE_DROP:
                if (t.pos > cnt)
                    r.stat = iqrs_pkg::STATUS_RANGE;
                else
                begin
                    shadow_head = slot_at(t.pos);
                    shadow_count = shadow_count - t.pos;
                end
            iqrs_pkg::MODE_CLEAR:
            begin
                shadow_head = '0;
                shadow_count = '0;
            end
            default:
                if (t.pos >= cnt || t.pos_high >= cnt)
                    r.stat = iqrs_pkg::STATUS_RANGE;
                else
                    for (int i = t.pos + 1; i <= t.pos_high; i++)
                    begin
                        key = shadow_mem[slot_at(i)];
                        j = i;
                        while (j > t.pos && shadow_mem[slot_at(j - 1)] > key)
                        begin
                            shadow_mem[slot_at(j)] = shadow_mem[slot_at(j - 1)];
                            j--;
                        end
                        shadow_mem[slot_at(j)] = key;
                    end
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [iqrs_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 15))) - 8;
            default: return $urandom;
        endcase
    endfunction

    // queue one transaction and track how many entries it leaves
    task automatic add_op(input iqrs_pkg::mode_t op,
                          input logic signed [iqrs_pkg::WORD_W-1:0] w,
                          input int p, input int ph);
        queue_op_t t;
        t.op = op;
        t.word = w;
        t.pos = p[iqrs_pkg::COUNT_W-1:0];
        t.pos_high = ph[iqrs_pkg::ADDR_W-1:0];
        t.gap = pick_gap();
        pending_ops.push_back(t);
        case (op)
            iqrs_pkg::MODE_PUSH:  if (gen_count < iqrs_pkg::CAPACITY) gen_count++;
            iqrs_pkg::MODE_POP:   if (gen_count > 0) gen_count--;
            iqrs_pkg::MODE_DROP:  if (p <= gen_count) gen_count -= p;
            iqrs_pkg::MODE_CLEAR: gen_count = 0;
            default: ;
        endcase
    endtask

    task automatic add_random_op(input int push_weight);
        int r;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        if (r < push_weight)
            add_op(iqrs_pkg::MODE_PUSH, pick_word(), $urandom_range(0, 511), $urandom);
        else if (r < push_weight + 12)
            add_op(iqrs_pkg::MODE_POP, pick_word(), $urandom_range(0, 511), $urandom);
        else if (r < push_weight + 17)
            add_op(iqrs_pkg::MODE_PEEK, pick_word(), $urandom_range(0, 511), $urandom);
        else if (r < push_weight + 29)
            add_op(iqrs_pkg::MODE_READ, 0,
                   gen_count > 0 ? $urandom_range(0, gen_count - 1) : 0, $urandom);
        else if (r < push_weight + 40)
            add_op(iqrs_pkg::MODE_WRITE, pick_word(),
                   gen_count > 0 ? $urandom_range(0, gen_count - 1) : 0, $urandom);
        else if (r < push_weight + 45)
        begin
            lo = $urandom_range(0, 9);
            hi = (lo == 0) ? gen_count : (lo == 1) ? gen_count + 1 :
                 $urandom_range(0, gen_count < 6 ? gen_count : 6);
            add_op(iqrs_pkg::MODE_DROP, pick_word(), hi, $urandom);
        end
        else if (r < push_weight + 47)
            add_op(iqrs_pkg::MODE_CLEAR, pick_word(), $urandom_range(0, 511), $urandom);
        else if (r < push_weight + 58 && gen_count > 0)
        begin
            // mostly short in-range sorts, with an occasional long one
            lo = $urandom_range(0, gen_count - 1);
            if ($urandom_range(0, 99) == 0)
            begin
                lo = 0;
                hi = gen_count - 1;
            end
            else
                hi = lo + $urandom_range(0, 12) - 2;
            if (hi >= gen_count)
                hi = gen_count - 1;
            if (hi < 0)
                hi = 0;
            add_op(iqrs_pkg::MODE_SORT, pick_word(), lo, hi);
        end
        else
            // noise: any mode with unconstrained index fields
            add_op(iqrs_pkg::mode_t'($urandom_range(0, 7)), $urandom,
                   $urandom_range(0, 511), $urandom);
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = iqrs_pkg::MODE_PUSH;
        value = '0;
        index = '0;
        index_high = '0;
        out_ready = 1'b0;
        gen_count = 0;

        add_op(iqrs_pkg::MODE_POP, 0, 0, 0);
        add_op(iqrs_pkg::MODE_PEEK, 0, 0, 0);
        add_op(iqrs_pkg::MODE_READ, 0, 0, 0);
        add_op(iqrs_pkg::MODE_WRITE, 32'sd9, 0, 0);
        add_op(iqrs_pkg::MODE_DROP, 0, 1, 0);
        add_op(iqrs_pkg::MODE_DROP, 0, 0, 0);
        add_op(iqrs_pkg::MODE_SORT, 0, 0, 0);
        add_op(iqrs_pkg::MODE_PUSH, 32'sh7fffffff, 0, 0);
        add_op(iqrs_pkg::MODE_PUSH, 32'sh80000000, 0, 0);
        add_op(iqrs_pkg::MODE_PUSH, -32'sd1, 0, 0);
        add_op(iqrs_pkg::MODE_PUSH, 32'sd0, 0, 0);
        add_op(iqrs_pkg::MODE_PUSH, 32'sd1, 0, 0);
        add_op(iqrs_pkg::MODE_PEEK, 0, 0, 0);
        add_op(iqrs_pkg::MODE_READ, 0, 4, 0);
        add_op(iqrs_pkg::MODE_READ, 0, 5, 0);
        add_op(iqrs_pkg::MODE_READ, 0, 511, 255);
        add_op(iqrs_pkg::MODE_WRITE, 32'sd5, 2, 0);
        add_op(iqrs_pkg::MODE_SORT, 0, 0, 4);
        add_op(iqrs_pkg::MODE_SORT, 0, 3, 1);
        add_op(iqrs_pkg::MODE_SORT, 0, 0, 5);
        add_op(iqrs_pkg::MODE_SORT, 0, 256, 2);
        add_op(iqrs_pkg::MODE_DROP, 0, 2, 0);
        add_op(iqrs_pkg::MODE_DROP, 0, 4, 0);
        add_op(iqrs_pkg::MODE_CLEAR, 0, 0, 0);
        add_op(iqrs_pkg::MODE_POP, 0, 0, 0);

        // fill to capacity, hit full, sort the whole queue, then drain partly
        while (gen_count < iqrs_pkg::CAPACITY)
            add_random_op(85);
        add_op(iqrs_pkg::MODE_PUSH, pick_word(), 0, 0);
        add_op(iqrs_pkg::MODE_PUSH, pick_word(), 0, 0);
        add_op(iqrs_pkg::MODE_READ, 0, 255, 0);
        add_op(iqrs_pkg::MODE_READ, 0, 256, 0);
        add_op(iqrs_pkg::MODE_SORT, 0, 0, 255);
        add_op(iqrs_pkg::MODE_DROP, 0, 200, 0);
        while (pending_ops.size() < 850)
            add_random_op(gen_count > 40 ? 18 : 32);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d transactions accepted, %0d results checked", accepted, results_seen);
        $display("%0d range sorts done, %0d pushes refused as full", sorts_done, full_hits);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    mode <= pending_ops[0].op;
                    value <= pending_ops[0].word;
                    index <= pending_ops[0].pos;
                    index_high <= pending_ops[0].pos_high;
                    gap_left <= pending_ops[0].gap;
                    in_valid <= 1'b1;
                    void'(pending_ops.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver readiness, with one long hold-off while the sender keeps offering
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && accepted >= 400)
            begin
                long_hold_done <= 1'b1;
                hold_left <= 300;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 70)
                out_ready <= 1'b1;
            else
            begin
                hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                         : $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
        end
    end

    // input acceptance and prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
            shadow_head = '0;
            shadow_count = '0;
        end
        else
        begin
            queue_op_t t;
            in_took <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                t.op = mode;
                t.word = value;
                t.pos = index;
                t.pos_high = index_high;
                if (mode == iqrs_pkg::MODE_SORT && index < shadow_count
                    && index_high < shadow_count)
                    sorts_done++;
                if (mode == iqrs_pkg::MODE_PUSH && shadow_count >= iqrs_pkg::CAPACITY)
                    full_hits++;
                expected_results.push_back(apply_queue_op(t));
                accepted++;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            queue_result_t want;
            if (expected_results.size() == 0)
                report_mismatch("result with no transaction outstanding", data, '0);
            else
            begin
                want = expected_results.pop_front();
                if (data !== want.word)
                    report_mismatch("data", data, want.word);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", entry_count, want.count);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
